// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = ROW_W + COL_W;
  localparam int PH_W    = $clog2(TAB_STOP);
  localparam int CHAR_W  = 8;
  localparam int ENTRY_W = 16;
  localparam int POS_W   = 11;
  localparam int KIND_W  = 2;

  localparam int AREA_START   = COLUMNS;
  localparam int SCROLL_START = 2 * COLUMNS;
  localparam int AREA_END     = (ROWS - 1) * COLUMNS - 1;

  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUTXY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // Pointer operations
  localparam logic [2:0] PTR_HOLD   = 3'd0;
  localparam logic [2:0] PTR_CURSOR = 3'd1;
  localparam logic [2:0] PTR_XY     = 3'd2;
  localparam logic [2:0] PTR_AREA   = 3'd3;
  localparam logic [2:0] PTR_SCROLL = 3'd4;
  localparam logic [2:0] PTR_INC    = 3'd5;

  // Cursor operations
  localparam logic [2:0] CUR_HOLD = 3'd0;
  localparam logic [2:0] CUR_INC  = 3'd1;
  localparam logic [2:0] CUR_WRAP = 3'd2;
  localparam logic [2:0] CUR_COL0 = 3'd3;
  localparam logic [2:0] CUR_HOME = 3'd4;

  // Write data selection
  localparam logic [1:0] WD_SPACE = 2'd0;
  localparam logic [1:0] WD_CHAR  = 2'd1;
  localparam logic [1:0] WD_RESET = 2'd2;
  localparam logic [1:0] WD_COPY  = 2'd3;

  typedef struct packed {
    logic       take;
    logic [2:0] ptr_op;
    logic [2:0] cur_op;
    logic       mem_we;
    logic [1:0] wd_sel;
    logic       wa_back;
    logic       scr_set;
    logic       entry_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_nl;
    logic              is_cr;
    logic              is_tab;
    logic              xy_ok;
    logic              col_last;
    logic              row_last;
    logic              phase_last;
    logic              ptr_top;
    logic              ptr_area_end;
    logic              rd_nl;
    logic              out_busy;
  } sts_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: decodes each item and steps the
// datapath through writes, reads, fills and the scroll copy.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DECODE   = 4'd2;
  localparam logic [3:0] ST_PUT      = 4'd3;
  localparam logic [3:0] ST_LINE     = 4'd4;
  localparam logic [3:0] ST_CR_RD    = 4'd5;
  localparam logic [3:0] ST_CR_CHK   = 4'd6;
  localparam logic [3:0] ST_TAB      = 4'd7;
  localparam logic [3:0] ST_SCR_RD   = 4'd8;
  localparam logic [3:0] ST_SCR_WR   = 4'd9;
  localparam logic [3:0] ST_SCR_FILL = 4'd10;
  localparam logic [3:0] ST_FILL     = 4'd11;
  localparam logic [3:0] ST_PUTXY    = 4'd12;
  localparam logic [3:0] ST_RD       = 4'd13;
  localparam logic [3:0] ST_RD_WAIT  = 4'd14;
  localparam logic [3:0] ST_FINISH   = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_CLR: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_RESET;
        cmd.ptr_op = tcw_pkg::PTR_INC;
        if (sts.ptr_top) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.kind)
          tcw_pkg::KIND_PUT: begin
            cmd.ptr_op = tcw_pkg::PTR_CURSOR;
            if (sts.is_nl) begin
              state_nxt = ST_LINE;
            end else if (sts.is_cr) begin
              state_nxt = ST_CR_RD;
            end else if (sts.is_tab) begin
              state_nxt = ST_TAB;
            end else begin
              state_nxt = ST_PUT;
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            cmd.ptr_op = tcw_pkg::PTR_AREA;
            cmd.cur_op = tcw_pkg::CUR_HOME;
            state_nxt  = ST_FILL;
          end
          tcw_pkg::KIND_PUTXY: begin
            cmd.ptr_op = tcw_pkg::PTR_XY;
            state_nxt  = sts.xy_ok ? ST_PUTXY : ST_FINISH;
          end
          default: begin
            cmd.ptr_op = tcw_pkg::PTR_XY;
            state_nxt  = sts.xy_ok ? ST_RD : ST_FINISH;
          end
        endcase
      end
      ST_PUT: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_CHAR;
        if (!sts.col_last) begin
          cmd.cur_op = tcw_pkg::CUR_INC;
          state_nxt  = ST_FINISH;
        end else if (sts.row_last) begin
          cmd.cur_op  = tcw_pkg::CUR_COL0;
          cmd.ptr_op  = tcw_pkg::PTR_SCROLL;
          cmd.scr_set = 1'b1;
          state_nxt   = ST_SCR_RD;
        end else begin
          cmd.cur_op = tcw_pkg::CUR_WRAP;
          state_nxt  = ST_FINISH;
        end
      end
      ST_LINE: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_SPACE;
        cmd.ptr_op = tcw_pkg::PTR_INC;
        if (!sts.col_last) begin
          cmd.cur_op = tcw_pkg::CUR_INC;
        end else if (sts.row_last) begin
          cmd.cur_op  = tcw_pkg::CUR_COL0;
          cmd.ptr_op  = tcw_pkg::PTR_SCROLL;
          cmd.scr_set = 1'b1;
          state_nxt   = ST_SCR_RD;
        end else begin
          cmd.cur_op = tcw_pkg::CUR_WRAP;
          state_nxt  = ST_FINISH;
        end
      end
      ST_CR_RD: begin
        state_nxt = ST_CR_CHK;
      end
      ST_CR_CHK: begin
        // A carriage return over a stored newline code leaves everything as is.
        state_nxt = sts.rd_nl ? ST_FINISH : ST_LINE;
      end
      ST_TAB: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_SPACE;
        cmd.ptr_op = tcw_pkg::PTR_INC;
        if (!sts.col_last) begin
          cmd.cur_op = tcw_pkg::CUR_INC;
          if (sts.phase_last) begin
            state_nxt = ST_FINISH;
          end
        end else if (sts.row_last) begin
          cmd.cur_op  = tcw_pkg::CUR_COL0;
          cmd.ptr_op  = tcw_pkg::PTR_SCROLL;
          cmd.scr_set = 1'b1;
          state_nxt   = ST_SCR_RD;
        end else begin
          cmd.cur_op = tcw_pkg::CUR_WRAP;
          state_nxt  = ST_FINISH;
        end
      end
      ST_SCR_RD: begin
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.mem_we  = 1'b1;
        cmd.wd_sel  = tcw_pkg::WD_COPY;
        cmd.wa_back = 1'b1;
        cmd.ptr_op  = tcw_pkg::PTR_INC;
        state_nxt   = sts.ptr_area_end ? ST_SCR_FILL : ST_SCR_RD;
      end
      ST_SCR_FILL: begin
        // The pointer runs one row ahead of the blanked row.
        cmd.mem_we  = 1'b1;
        cmd.wd_sel  = tcw_pkg::WD_SPACE;
        cmd.wa_back = 1'b1;
        cmd.ptr_op  = tcw_pkg::PTR_INC;
        if (sts.ptr_top) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_SPACE;
        cmd.ptr_op = tcw_pkg::PTR_INC;
        if (sts.ptr_area_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PUTXY: begin
        cmd.mem_we = 1'b1;
        cmd.wd_sel = tcw_pkg::WD_CHAR;
        state_nxt  = ST_FINISH;
      end
      ST_RD: begin
        state_nxt = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd.entry_load = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded while the output register is still held");

  a_take_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_DECODE)
    else $error("accepted item not decoded in the next cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FINISH) |-> !cmd.mem_we)
    else $error("text store written outside an item's work");
`endif

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, color, store pointer, text store and result register of the text
// console writer, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::sts_t               sts,
  input  logic [tcw_pkg::KIND_W-1:0]  in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char,
  input  logic [tcw_pkg::COL_W-1:0]   in_col,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::CHAR_W-1:0]  cfg_wr_data,
  input  logic                        out_tready,
  output logic                        out_valid,
  output logic [tcw_pkg::POS_W-1:0]   out_pos,
  output logic [tcw_pkg::ENTRY_W-1:0] out_entry,
  output logic                        out_scroll
);

  logic [tcw_pkg::KIND_W-1:0]  kind_r;
  logic [tcw_pkg::CHAR_W-1:0]  char_r;
  logic [tcw_pkg::COL_W-1:0]   col_r;
  logic [tcw_pkg::ROW_W-1:0]   row_r;
  logic [tcw_pkg::CHAR_W-1:0]  color_r;
  logic [tcw_pkg::COL_W-1:0]   cursor_col_r, cursor_col_nxt;
  logic [tcw_pkg::ROW_W-1:0]   cursor_row_r, cursor_row_nxt;
  logic [tcw_pkg::PH_W-1:0]    phase_r, phase_nxt;
  logic [tcw_pkg::ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic                        scr_r;
  logic [tcw_pkg::ENTRY_W-1:0] entry_r;
  logic                        out_valid_r;
  logic [tcw_pkg::POS_W-1:0]   out_pos_r;
  logic [tcw_pkg::ENTRY_W-1:0] out_entry_r;
  logic                        out_scroll_r;

  logic [tcw_pkg::IDX_W-1:0]   cur_idx;
  logic [tcw_pkg::IDX_W-1:0]   xy_idx;
  logic [tcw_pkg::ADDR_W-1:0]  waddr;
  logic [tcw_pkg::ENTRY_W-1:0] wdata;
  logic [tcw_pkg::ENTRY_W-1:0] rdata;

  assign cur_idx = cursor_row_r * tcw_pkg::IDX_W'(tcw_pkg::COLUMNS)
                 + tcw_pkg::IDX_W'(cursor_col_r);
  assign xy_idx  = row_r * tcw_pkg::IDX_W'(tcw_pkg::COLUMNS) + tcw_pkg::IDX_W'(col_r);

  // Input latch and color register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= in_kind;
      char_r <= in_char;
      col_r  <= in_col;
      row_r  <= in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcw_pkg::RESET_COLOR;
    end else if (cfg_wr_en) begin
      color_r <= cfg_wr_data;
    end
  end

  // Cursor, with the column's position inside its tab stop kept alongside.
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    phase_nxt      = phase_r;
    case (cmd.cur_op)
      tcw_pkg::CUR_INC: begin
        cursor_col_nxt = cursor_col_r + tcw_pkg::COL_W'(1);
        phase_nxt      = sts.phase_last ? '0 : phase_r + tcw_pkg::PH_W'(1);
      end
      tcw_pkg::CUR_WRAP: begin
        cursor_col_nxt = '0;
        cursor_row_nxt = cursor_row_r + tcw_pkg::ROW_W'(1);
        phase_nxt      = '0;
      end
      tcw_pkg::CUR_COL0: begin
        cursor_col_nxt = '0;
        phase_nxt      = '0;
      end
      tcw_pkg::CUR_HOME: begin
        cursor_col_nxt = '0;
        cursor_row_nxt = tcw_pkg::ROW_W'(1);
        phase_nxt      = '0;
      end
      default: begin
        cursor_col_nxt = cursor_col_r;
      end
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    case (cmd.ptr_op)
      tcw_pkg::PTR_CURSOR: ptr_nxt = tcw_pkg::ADDR_W'(cur_idx);
      tcw_pkg::PTR_XY:     ptr_nxt = tcw_pkg::ADDR_W'(xy_idx);
      tcw_pkg::PTR_AREA:   ptr_nxt = tcw_pkg::ADDR_W'(tcw_pkg::AREA_START);
      tcw_pkg::PTR_SCROLL: ptr_nxt = tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_START);
      tcw_pkg::PTR_INC:    ptr_nxt = ptr_r + tcw_pkg::ADDR_W'(1);
      default:             ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= tcw_pkg::ROW_W'(1);
      phase_r      <= '0;
      ptr_r        <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      phase_r      <= phase_nxt;
      ptr_r        <= ptr_nxt;
    end
  end

  // Text store
  assign waddr = cmd.wa_back ? ptr_r - tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) : ptr_r;

  always_comb begin
    case (cmd.wd_sel)
      tcw_pkg::WD_CHAR:  wdata = {color_r, char_r};
      tcw_pkg::WD_RESET: wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE};
      tcw_pkg::WD_COPY:  wdata = rdata;
      default:           wdata = {color_r, tcw_pkg::CH_SPACE};
    endcase
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::ENTRY_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  // Per-item result fields
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      scr_r   <= 1'b0;
      entry_r <= '0;
    end else begin
      if (cmd.scr_set) begin
        scr_r <= 1'b1;
      end
      if (cmd.entry_load) begin
        entry_r <= rdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pos_r    <= tcw_pkg::POS_W'(cur_idx);
      out_entry_r  <= entry_r;
      out_scroll_r <= scr_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pos    = out_pos_r;
  assign out_entry  = out_entry_r;
  assign out_scroll = out_scroll_r;

  // Status to the sequencer
  always_comb begin
    sts.kind         = kind_r;
    sts.is_nl        = (char_r == tcw_pkg::CH_NL);
    sts.is_cr        = (char_r == tcw_pkg::CH_CR);
    sts.is_tab       = (char_r == tcw_pkg::CH_TAB);
    sts.xy_ok        = (tcw_pkg::IDX_W'(col_r) < tcw_pkg::IDX_W'(tcw_pkg::COLUMNS))
                    && (tcw_pkg::IDX_W'(row_r) < tcw_pkg::IDX_W'(tcw_pkg::ROWS));
    sts.col_last     = (cursor_col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    sts.row_last     = (cursor_row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 2));
    sts.phase_last   = (phase_r == tcw_pkg::PH_W'(tcw_pkg::TAB_STOP - 1));
    sts.ptr_top      = (ptr_r == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
    sts.ptr_area_end = (ptr_r == tcw_pkg::ADDR_W'(tcw_pkg::AREA_END));
    sts.rd_nl        = (rdata[tcw_pkg::CHAR_W-1:0] == tcw_pkg::CH_NL);
    sts.out_busy     = out_valid_r && !out_tready;
  end

`ifndef ASSERT_OFF
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> !scr_r && entry_r == '0)
    else $error("per-item result fields not cleared on accept");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scr_set |-> sts.row_last && sts.col_last)
    else $error("scroll started with the cursor away from the area's end");

  a_back_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_we && cmd.wa_back) |->
      (ptr_r >= tcw_pkg::ADDR_W'(tcw_pkg::SCROLL_START)))
    else $error("scroll write would land above the scroll area");
`endif

endmodule

// ----- rtl/core/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell terminal engine over an 80x25 store of color/char entries.
// ----------------------------------------------------------------------------
// Items are handled one at a time, from the accept cycle through the result load: a plain
// character or a put at (x,y) writes one cell, a cell read reads one, a newline pads its row,
// a carriage return first reads its cell to check for a stored newline, a tab up to TAB_STOP writes.
// A scroll copies the area's rows up by one and blanks its last row; a clear fills the area.
// A result still held by out_tready low stalls the load of the next one.
// Reset: synchronous active-low; store swept to space/0x07, cursor row 1.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], cell_col[14:8], cell_row[19:15]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_pos[10:0], cell_entry[26:11], did_scroll[27]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data // text_color
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  logic [tcw_pkg::POS_W-1:0]   out_pos;
  logic [tcw_pkg::ENTRY_W-1:0] out_entry;
  logic                        out_scroll;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_tuser),
    .in_char     (in_tdata[7:0]),
    .in_col      (in_tdata[14:8]),
    .in_row      (in_tdata[19:15]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_pos     (out_pos),
    .out_entry   (out_entry),
    .out_scroll  (out_scroll)
  );

  assign out_tdata = {4'b0000, out_scroll, out_entry, out_pos};

endmodule
